// File: sv/rcafe_pkg.sv
package rcafe_pkg;

	localparam int CODE_BITS = 12;
	localparam int BCNT_W    = $clog2(CODE_BITS + 1);
	localparam int UNIT_W    = 8;
	localparam int WAIT_W    = 8;
	localparam int DUR_W     = 11;
	localparam int OP_W      = 2;
	localparam int S_DATA_W  = ((CODE_BITS + 7) / 8) * 8;
	localparam int M_FIELD_W = 1 + DUR_W + 1 + 1;
	localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
	localparam int ADDR_W    = 3;
	localparam int APB_W     = 32;

	localparam logic [UNIT_W-1:0] UNIT_TIME_RST  = UNIT_W'(28);
	localparam logic [WAIT_W-1:0] WAIT_UNITS_RST = WAIT_W'(16);

	// register select is the word address bit
	localparam logic REG_UNIT_TIME  = 1'b0;
	localparam logic REG_WAIT_UNITS = 1'b1;

	// shift amounts for 1, 2, 4 and 8 units
	localparam logic [1:0] SH_1U = 2'd0;
	localparam logic [1:0] SH_2U = 2'd1;
	localparam logic [1:0] SH_4U = 2'd2;
	localparam logic [1:0] SH_8U = 2'd3;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_SEND = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HDR_M  = 4'd1,
		PH_HDR_S  = 4'd2,
		PH_BIT_M  = 4'd3,
		PH_BIT_S  = 4'd4,
		PH_IBIT_M = 4'd5,
		PH_IBIT_S = 4'd6,
		PH_STOP   = 4'd7,
		PH_WAIT   = 4'd8
	} phase_t;

	function automatic logic [DUR_W-1:0] dur_units(input logic [UNIT_W-1:0] ut,
			input logic [1:0] sh);
		logic [DUR_W-1:0] w;
		w = DUR_W'(ut);
		return w << sh;
	endfunction

endpackage

// File: sv/rca_ir_frame_encoder_unit.sv
// A request taken into the input register gives its result on m_tdata through the result register.
// Throughput: one request per cycle while the result is not stalled; the phase sequencer updates in one pass.
// Input and result registers decouple the sides; s_tready falls only while both are full
// and the result is stalled.
// Reset (arst_n low, asynchronous): idle, carrier off, duration 28 periods,
// unit_time 28, wait_units 16, both register stages empty.
module rca_ir_frame_encoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rcafe_pkg::S_DATA_W-1:0]  s_tdata,  // code, zero pad
	input  logic [rcafe_pkg::OP_W-1:0]      s_tuser,  // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rcafe_pkg::M_DATA_W-1:0]  m_tdata,  // carrier_on, duration, accepted, idle, pad
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rcafe_pkg::ADDR_W-1:0]    paddr,
	input  logic [rcafe_pkg::APB_W-1:0]     pwdata,
	output logic [rcafe_pkg::APB_W-1:0]     prdata,
	output logic                            pready
);

	localparam int CB = rcafe_pkg::CODE_BITS;

	logic [rcafe_pkg::UNIT_W-1:0] unit_time_q;
	logic [rcafe_pkg::WAIT_W-1:0] wait_units_q;

	logic                         valid_s1;
	logic [rcafe_pkg::OP_W-1:0]   op_s1;
	logic [CB-1:0]                code_s1;

	rcafe_pkg::phase_t             phase_q, phase_d;
	logic [CB-1:0]                 shift_q, shift_d;
	logic [CB-1:0]                 active_q, active_d;
	logic [rcafe_pkg::BCNT_W-1:0]  bcnt_q, bcnt_d, bcnt_inc;
	logic [rcafe_pkg::WAIT_W-1:0]  wcnt_q, wcnt_d, wcnt_inc;
	logic                          rpt_q, rpt_d;
	logic                          carrier_q, carrier_d;
	logic [rcafe_pkg::DUR_W-1:0]   dur_q, dur_d;
	logic                          acc_d;

	logic                          out_valid_q;
	logic [rcafe_pkg::M_DATA_W-1:0] out_data_q;

	logic advance, step, cfg_wr;

	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_time_q  <= rcafe_pkg::UNIT_TIME_RST;
			wait_units_q <= rcafe_pkg::WAIT_UNITS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == rcafe_pkg::REG_UNIT_TIME) begin
				unit_time_q <= pwdata[rcafe_pkg::UNIT_W-1:0];
			end else begin
				wait_units_q <= pwdata[rcafe_pkg::WAIT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == rcafe_pkg::REG_WAIT_UNITS) begin
			prdata = rcafe_pkg::APB_W'(wait_units_q);
		end else begin
			prdata = rcafe_pkg::APB_W'(unit_time_q);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			code_s1 <= s_tdata[CB-1:0];
		end
	end

	// frame sequencer
	assign bcnt_inc = bcnt_q + rcafe_pkg::BCNT_W'(1);
	assign wcnt_inc = wcnt_q + rcafe_pkg::WAIT_W'(1);

	always_comb begin
		phase_d   = phase_q;
		shift_d   = shift_q;
		active_d  = active_q;
		bcnt_d    = bcnt_q;
		wcnt_d    = wcnt_q;
		rpt_d     = rpt_q;
		carrier_d = carrier_q;
		dur_d     = dur_q;
		acc_d     = 1'b0;
		case (op_s1)
			rcafe_pkg::OP_TICK: begin
				case (phase_q)
					rcafe_pkg::PH_IDLE: begin
						carrier_d = 1'b0;
					end
					rcafe_pkg::PH_HDR_M: begin
						dur_d     = rcafe_pkg::dur_units(unit_time_q, rcafe_pkg::SH_8U);
						carrier_d = 1'b1;
						phase_d   = rcafe_pkg::PH_HDR_S;
					end
					rcafe_pkg::PH_HDR_S: begin
						// space keeps the header mark length
						carrier_d = 1'b0;
						shift_d   = active_q;
						phase_d   = rcafe_pkg::PH_BIT_M;
					end
					rcafe_pkg::PH_BIT_M, rcafe_pkg::PH_IBIT_M, rcafe_pkg::PH_STOP: begin
						dur_d     = rcafe_pkg::dur_units(unit_time_q, rcafe_pkg::SH_1U);
						carrier_d = 1'b1;
						phase_d   = rcafe_pkg::phase_t'(phase_q + 4'd1);
					end
					rcafe_pkg::PH_BIT_S, rcafe_pkg::PH_IBIT_S: begin
						carrier_d = 1'b0;
						dur_d     = rcafe_pkg::dur_units(unit_time_q,
							shift_q[CB-1] ? rcafe_pkg::SH_4U : rcafe_pkg::SH_2U);
						shift_d   = shift_q << 1;
						bcnt_d    = bcnt_inc;
						if (bcnt_inc == rcafe_pkg::BCNT_W'(CB)) begin
							if (phase_q == rcafe_pkg::PH_BIT_S) begin
								shift_d = ~active_q;
								bcnt_d  = '0;
							end
							phase_d = rcafe_pkg::phase_t'(phase_q + 4'd1);
						end else begin
							phase_d = rcafe_pkg::phase_t'(phase_q - 4'd1);
						end
					end
					rcafe_pkg::PH_WAIT: begin
						carrier_d = 1'b0;
						dur_d     = rcafe_pkg::dur_units(unit_time_q, rcafe_pkg::SH_1U);
						wcnt_d    = wcnt_inc;
						if (wcnt_inc >= wait_units_q) begin
							bcnt_d  = '0;
							wcnt_d  = '0;
							phase_d = rpt_q ? rcafe_pkg::PH_HDR_M : rcafe_pkg::PH_IDLE;
						end
					end
					default: begin
						carrier_d = 1'b0;
						bcnt_d    = '0;
						wcnt_d    = '0;
						phase_d   = rcafe_pkg::PH_IDLE;
					end
				endcase
			end
			rcafe_pkg::OP_SEND: begin
				if (phase_q == rcafe_pkg::PH_IDLE && code_s1 != '0) begin
					active_d = code_s1;
					rpt_d    = 1'b1;
					bcnt_d   = '0;
					wcnt_d   = '0;
					phase_d  = rcafe_pkg::PH_HDR_M;
					acc_d    = 1'b1;
				end
			end
			rcafe_pkg::OP_STOP: begin
				rpt_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rcafe_pkg::PH_IDLE;
			shift_q   <= '0;
			active_q  <= '0;
			bcnt_q    <= '0;
			wcnt_q    <= '0;
			rpt_q     <= 1'b0;
			carrier_q <= 1'b0;
			dur_q     <= rcafe_pkg::DUR_W'(rcafe_pkg::UNIT_TIME_RST);
		end else if (step) begin
			phase_q   <= phase_d;
			shift_q   <= shift_d;
			active_q  <= active_d;
			bcnt_q    <= bcnt_d;
			wcnt_q    <= wcnt_d;
			rpt_q     <= rpt_d;
			carrier_q <= carrier_d;
			dur_q     <= dur_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= rcafe_pkg::M_DATA_W'({(phase_d == rcafe_pkg::PH_IDLE), acc_d,
				dur_d, carrier_d});
		end
	end

endmodule

// File: sv/rcafe_checker.sv
module rcafe_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rcafe_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int ACC_BIT  = rcafe_pkg::DUR_W + 1;
	localparam int IDLE_BIT = rcafe_pkg::DUR_W + 2;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// with the result stage empty nothing blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty result stage");

	// a started frame is never idle
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[ACC_BIT] |-> !m_tdata[IDLE_BIT])
		else $error("accepted send reported idle");

	// frames start and end with the carrier off
	a_acc_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[ACC_BIT] |-> !m_tdata[0])
		else $error("carrier on at frame start");

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[IDLE_BIT] |-> !m_tdata[0])
		else $error("carrier on while idle");

endmodule

bind rca_ir_frame_encoder_unit rcafe_checker u_rcafe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
